[rtl/rhht_pkg.sv]
// rhht_pkg: shared types and constants of the Robin Hood hash table.
// Depends on nothing; used by rhht_slot_mem, robin_hood_hash_table, rhht_chk and tb.
package rhht_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned PSL_W    = IDX_W + 1;
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'((CAPACITY * 3) / 4);
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_GET   = 2'd1,
    REQ_DEL   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_FRD,
    S_FCHK,
    S_IRD,
    S_ICHK,
    S_DRD,
    S_DCHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             we;
    logic             set_v;
    logic             clr_v;
    logic             clr_all;
    logic [IDX_W-1:0] addr;
  } slot_wr_t;

endpackage

[rtl/robin_hood_hash_table.sv]
// robin_hood_hash_table: FNV-1a hashed Robin Hood table, 256 slots, back-shift delete.
// Depends on rhht_pkg and rhht_slot_mem.
//
// channel  dir  tdata (low bit up)                      tuser
// s_axis   in   key[63:0], new_value[95:64]            req_type
// m_axis   out  found[0], old_value[32:1], count[41:33] status
//
// One item at a time: accept, KEY_BYTES hash steps (one multiply each), then
// a read state and a check state per slot probed and per slot walked by insert or
// back-shift, then the result register holds until taken. Clear skips hash and probe.
// The registered read of the slot memory sets the per-slot cost. Reset empties the table at once.
module robin_hood_hash_table #(
  parameter int unsigned KEY_BYTES  = 8,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // key[63:0], new_value[95:64]
  input  logic [1:0]    s_axis_tuser,   // req_type
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,   // found, old_value, entry_count, zero pad
  output logic [1:0]    m_axis_tuser    // status
);
  import rhht_pkg::*;

  localparam int unsigned KW  = 8 * KEY_BYTES;
  localparam int unsigned HCW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  typedef struct packed {
    logic [31:0]           hash;
    logic [KW-1:0]         key;
    logic [VALUE_BITS-1:0] val;
    logic [PSL_W-1:0]      psl;
  } ent_t;

  state_e state_q, state_d;
  req_e   req_q, req_d;
  logic [KW-1:0]         key_q, key_d, hk_q, hk_d;
  logic [VALUE_BITS-1:0] val_q, val_d, in_val;
  logic [31:0]           h_q, h_d, h_nx, rd_v32;
  logic [HCW-1:0]        hcnt_q, hcnt_d;
  logic [IDX_W-1:0]      idx_q, idx_d, rd_addr;
  logic [PSL_W-1:0]      psl_q, psl_d;
  logic [IDX_W-1:0]      n_q, n_d;
  ent_t                  car_q, car_d, rd, wdata;
  logic                  found_q, found_d;
  logic [31:0]           old_q, old_d;
  status_e               status_q, status_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  slot_wr_t              wr;
  logic [$bits(ent_t)-1:0] rd_raw;
  logic                  rd_valid, acc, stop, eq, match, miss, full, del_end;

  for (genvar i = 0; i < 32; i++) begin : g_v32
    if (i < VALUE_BITS) begin : g_in
      assign rd_v32[i] = rd.val[i];
    end else begin : g_out
      assign rd_v32[i] = 1'b0;
    end
  end
  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_vin
    if (i < 32) begin : g_in
      assign in_val[i] = s_axis_tdata[64+i];
    end else begin : g_out
      assign in_val[i] = 1'b0;
    end
  end

  rhht_slot_mem #(.W($bits(ent_t))) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .wr_data_i  (wdata),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_raw),
    .rd_valid_o (rd_valid)
  );
  assign rd = ent_t'(rd_raw);

  assign acc     = s_axis_tvalid && s_axis_tready;
  assign h_nx    = (h_q ^ {24'd0, hk_q[7:0]}) * FNV_PRIME;
  assign stop    = !rd_valid || (psl_q > rd.psl);
  assign eq      = (rd.hash == h_q) && (rd.key == key_q);
  assign match   = !stop && eq;
  assign miss    = stop || (!eq && (n_q == IDX_W'(CAPACITY - 1)));
  assign full    = cnt_q >= FULL_CNT;
  assign del_end = !rd_valid || (rd.psl <= PSL_W'(1));
  assign rd_addr = (state_q == S_DRD) ? idx_q + 1'b1 : idx_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_RESP);
  assign m_axis_tdata  = {6'd0, cnt_q, old_q, found_q};
  assign m_axis_tuser  = status_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc) begin
        state_d = (req_e'(s_axis_tuser) == REQ_CLEAR) ? S_RESP : S_HASH;
      end
      S_HASH: if (hcnt_q == HCW'(KEY_BYTES - 1)) begin
        state_d = S_FRD;
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (match) begin
          state_d = (req_q == REQ_DEL) ? S_DRD : S_RESP;
        end else if (miss) begin
          state_d = (req_q == REQ_SET && !full) ? S_IRD : S_RESP;
        end else begin
          state_d = S_FRD;
        end
      end
      S_IRD:  state_d = S_ICHK;
      S_ICHK: state_d = rd_valid ? S_IRD : S_RESP;
      S_DRD:  state_d = S_DCHK;
      S_DCHK: state_d = del_end ? S_RESP : S_DRD;
      S_RESP: if (m_axis_tready) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d = req_q; key_d = key_q; val_d = val_q; h_d = h_q; hk_d = hk_q;
    hcnt_d = hcnt_q; idx_d = idx_q; psl_d = psl_q; n_d = n_q; car_d = car_q;
    found_d = found_q; old_d = old_q; status_d = status_q; cnt_d = cnt_q;
    wr = '0;
    wr.addr = idx_q;
    wdata = car_q;
    case (state_q)
      S_IDLE: if (acc) begin
        req_d    = req_e'(s_axis_tuser);
        key_d    = s_axis_tdata[KW-1:0];
        hk_d     = s_axis_tdata[KW-1:0];
        val_d    = in_val;
        h_d      = FNV_BASIS;
        hcnt_d   = '0;
        found_d  = 1'b0;
        old_d    = '0;
        status_d = ST_OK;
        if (req_e'(s_axis_tuser) == REQ_CLEAR) begin
          wr.clr_all = 1'b1;
          cnt_d      = '0;
        end
      end
      S_HASH: begin
        h_d    = h_nx;
        hk_d   = hk_q >> 8;
        hcnt_d = hcnt_q + 1'b1;
        idx_d  = h_nx[IDX_W-1:0];
        psl_d  = PSL_W'(1);
        n_d    = '0;
      end
      S_FCHK: begin
        if (match) begin
          found_d = 1'b1;
          old_d   = rd_v32;
          if (req_q == REQ_SET) begin
            wdata     = rd;
            wdata.val = val_q;
            wr.we     = 1'b1;
          end
        end else if (miss) begin
          if (req_q == REQ_SET) begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              idx_d = h_q[IDX_W-1:0];
              car_d = '{hash: h_q, key: key_q, val: val_q, psl: PSL_W'(1)};
            end
          end else begin
            status_d = ST_NOTFOUND;
          end
        end else begin
          psl_d = psl_q + 1'b1;
          idx_d = idx_q + 1'b1;
          n_d   = n_q + 1'b1;
        end
      end
      S_ICHK: begin
        idx_d = idx_q + 1'b1;
        if (!rd_valid) begin
          wr.we    = 1'b1;
          wr.set_v = 1'b1;
          cnt_d    = cnt_q + 1'b1;
        end else if (car_q.psl > rd.psl) begin
          wr.we     = 1'b1;
          car_d     = rd;
          car_d.psl = rd.psl + 1'b1;
        end else begin
          car_d.psl = car_q.psl + 1'b1;
        end
      end
      S_DCHK: begin
        if (del_end) begin
          wr.clr_v = 1'b1;
          cnt_d    = cnt_q - 1'b1;
        end else begin
          wdata     = rd;
          wdata.psl = rd.psl - 1'b1;
          wr.we     = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    key_q    <= key_d;
    val_q    <= val_d;
    h_q      <= h_d;
    hk_q     <= hk_d;
    hcnt_q   <= hcnt_d;
    idx_q    <= idx_d;
    psl_q    <= psl_d;
    n_q      <= n_d;
    car_q    <= car_d;
    found_q  <= found_d;
    old_q    <= old_d;
    status_q <= status_d;
  end

endmodule

[rtl/rhht_slot_mem.sv]
// rhht_slot_mem: slot storage, one write and one registered read per cycle,
// plus per-slot occupied flags in flops. Depends on rhht_pkg.
module rhht_slot_mem #(
  parameter int unsigned W = 137
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rhht_pkg::slot_wr_t    wr_i,
  input  logic [W-1:0]          wr_data_i,
  input  logic [rhht_pkg::IDX_W-1:0] rd_addr_i,
  output logic [W-1:0]          rd_data_o,
  output logic                  rd_valid_o
);
  import rhht_pkg::*;

  logic [W-1:0]    mem [CAPACITY];
  logic [CAPACITY-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      rd_valid_o <= valid_q[rd_addr_i];
      if (wr_i.clr_all) begin
        valid_q <= '0;
      end else if (wr_i.set_v) begin
        valid_q[wr_i.addr] <= 1'b1;
      end else if (wr_i.clr_v) begin
        valid_q[wr_i.addr] <= 1'b0;
      end
    end
  end

endmodule

[rtl/rhht_chk.sv]
// rhht_chk: port-level checks of robin_hood_hash_table, bound to the top level.
// Depends on rhht_pkg.
module rhht_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [95:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import rhht_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input item dropped or changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("old value without hit");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[41:33] <= FULL_CNT &&
      !(m_axis_tuser == ST_FULL && m_axis_tdata[0]))
    else $error("load bound or full status broken");

endmodule

bind robin_hood_hash_table rhht_chk u_rhht_chk (.*);

[tb/tb.sv]
// tb: self-checking bench for robin_hood_hash_table (FNV-1a hashing, Robin Hood probing).
// Depends on rhht_pkg and the RTL; predicts every response with its own table model.
module tb;
  import rhht_pkg::*;

  localparam int unsigned NSLOT = 256;
  localparam longint unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic        found;
    logic [31:0] old_value;
    status_e     status;
    logic [8:0]  entry_count;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  robin_hood_hash_table dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // predictor state
  logic [8:0]  tbl_psl[NSLOT];
  logic [63:0] tbl_key[NSLOT];
  logic [31:0] tbl_val[NSLOT];
  logic [31:0] tbl_hash[NSLOT];
  int unsigned tbl_count;
  logic [63:0] live_keys[$];

  resp_t   pending_resp[$];
  int      errors = 0;
  longint  cycles = 0;
  int      burst_left = 0;
  bit      stall_mode = 0;

  function automatic logic [31:0] fnv1a(logic [63:0] k);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < 8; i++) begin
      h = h ^ {24'd0, k[8*i +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic int lookup_slot(logic [63:0] k, logic [31:0] h);
    int idx;
    int psl;
    idx = h % NSLOT;
    psl = 1;
    for (int n = 0; n < NSLOT; n++) begin
      if (tbl_psl[idx] == 0 || psl > tbl_psl[idx]) return -1;
      if (tbl_hash[idx] == h && tbl_key[idx] == k) return idx;
      psl++;
      idx = (idx + 1) % NSLOT;
    end
    return -1;
  endfunction

  function automatic void table_insert(logic [63:0] k, logic [31:0] v, logic [31:0] h);
    int idx;
    logic [63:0] ck, tk;
    logic [31:0] cv, ch, tv, th;
    logic [8:0] cp, tp;
    idx = h % NSLOT;
    ck = k; cv = v; ch = h; cp = 1;
    for (int n = 0; n < NSLOT; n++) begin
      if (tbl_psl[idx] == 0) begin
        tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_hash[idx] = ch; tbl_psl[idx] = cp;
        tbl_count++;
        return;
      end
      if (cp > tbl_psl[idx]) begin
        tk = tbl_key[idx]; tv = tbl_val[idx]; th = tbl_hash[idx]; tp = tbl_psl[idx];
        tbl_key[idx] = ck; tbl_val[idx] = cv; tbl_hash[idx] = ch; tbl_psl[idx] = cp;
        ck = tk; cv = tv; ch = th; cp = tp;
      end
      cp++;
      idx = (idx + 1) % NSLOT;
    end
  endfunction

  function automatic void table_remove(int idx);
    int nx;
    for (int n = 0; n < NSLOT; n++) begin
      nx = (idx + 1) % NSLOT;
      if (tbl_psl[nx] <= 1) break;
      tbl_key[idx] = tbl_key[nx];
      tbl_val[idx] = tbl_val[nx];
      tbl_hash[idx] = tbl_hash[nx];
      tbl_psl[idx] = tbl_psl[nx] - 1;
      idx = nx;
    end
    tbl_psl[idx] = 0;
    tbl_count--;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < NSLOT; i++) tbl_psl[i] = 0;
    tbl_count = 0;
    live_keys.delete();
  endfunction

  function automatic resp_t predict_request(req_e req, logic [63:0] k, logic [31:0] v);
    resp_t r;
    logic [31:0] h;
    int s;
    r = '{found: 1'b0, old_value: 32'd0, status: ST_OK, entry_count: 9'd0};
    if (req == REQ_CLEAR) begin
      table_clear();
    end else begin
      h = fnv1a(k);
      s = lookup_slot(k, h);
      if (s >= 0) begin
        r.found = 1'b1;
        r.old_value = tbl_val[s];
        if (req == REQ_SET) tbl_val[s] = v;
        else if (req == REQ_DEL) begin
          table_remove(s);
          foreach (live_keys[i]) if (live_keys[i] == k) begin
            live_keys.delete(i);
            break;
          end
        end
      end else if (req == REQ_SET) begin
        if (tbl_count * 4 >= NSLOT * 3) r.status = ST_FULL;
        else begin
          table_insert(k, v, h);
          live_keys.push_back(k);
        end
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    r.entry_count = tbl_count[8:0];
    return r;
  endfunction

  // sender: bursts with random gaps; tvalid is dropped when a burst ends
  task automatic send_request(req_e req, logic [63:0] k, logic [31:0] v);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, k};
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_resp.push_back(predict_request(req, k, v));
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_responses();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_resp.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (($urandom & 63) == 0) stall_mode <= ~stall_mode;
      m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    resp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{found: m_axis_tdata[0], old_value: m_axis_tdata[32:1],
              status: status_e'(m_axis_tuser), entry_count: m_axis_tdata[41:33]};
      if (pending_resp.size() == 0) begin
        $error("unexpected item: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d actual %0d", want.found, got.found); errors++;
        end
        if (got.old_value !== want.old_value) begin
          $error("old_value: expected %h actual %h", want.old_value, got.old_value); errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d actual %0d", want.entry_count,
                 got.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(0, 3) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 40)) : rand_key();
  endfunction

  task automatic test_directed();
    send_request(REQ_GET, 64'd0, 32'd0);
    send_request(REQ_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(REQ_SET, 64'd0, 32'hFFFF_FFFF);
    send_request(REQ_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(REQ_GET, 64'd0, 32'h1234_5678);
    send_request(REQ_SET, 64'd0, 32'hA5A5_5A5A);
    send_request(REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(REQ_DEL, 64'd0, 32'd0);
    send_request(REQ_GET, 64'd0, 32'd0);
    send_request(REQ_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_request(REQ_CLEAR, 64'd0, 32'd0);
  endtask

  // send more sets than three quarters of the slots hold, probe full status, then delete everything
  task automatic test_fill_and_drain();
    logic [63:0] k;
    for (int i = 0; i < 200; i++) send_request(REQ_SET, 64'(i) * 64'h9E37_79B9, $urandom);
    send_request(REQ_SET, 64'(7) * 64'h9E37_79B9, 32'hDEAD_BEEF);
    send_request(REQ_SET, rand_key(), $urandom);
    drain_responses();
    while (live_keys.size() != 0) begin
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
      send_request(REQ_DEL, k, $urandom);
      if ($urandom_range(0, 7) == 0) send_request(REQ_GET, pick_key(), $urandom);
    end
  endtask

  task automatic test_random();
    int r;
    for (int i = 0; i < 1100; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_request(REQ_SET, pick_key(), $urandom);
      else if (r < 70) send_request(REQ_GET, pick_key(), $urandom);
      else if (r < 98) send_request(REQ_DEL, pick_key(), $urandom);
      else send_request(REQ_CLEAR, rand_key(), $urandom);
      if (i == 500) drain_responses();
    end
  endtask

  initial begin
    table_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random();
    drain_responses();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

[sim.f]
rtl/rhht_pkg.sv
rtl/rhht_slot_mem.sv
rtl/robin_hood_hash_table.sv
rtl/rhht_chk.sv
tb/tb.sv
